// File: hdl/hfr_pkg.sv
package hfr_pkg;

    localparam int FRAME_BYTES_DEF = 1024;
    localparam int RING_BYTES_DEF  = 2048;
    localparam int HDR_BYTES       = 4;

    localparam logic [7:0] START_MARK = 8'h3C;
    localparam logic [7:0] END_MARK   = 8'h3E;

    localparam logic [1:0] OP_CHAR   = 2'd0;
    localparam logic [1:0] OP_DEQ    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_HDR   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_ROOM = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_TOO_BIG = 3'd3;
    localparam logic [2:0] ST_NO_DATA = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_char;
    } hfr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] cmd_id;
        logic [15:0] data_len;
        logic [7:0]  data_byte;
        logic        last;
    } hfr_out_t;

    // hex digit decode: bit 4 set when the character is a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// File: hdl/hex_frame_receiver_with_command_ring_top.sv
// flow: a data read passes S_RD0, S_RD1, S_OUT; a dequeue passes S_H0 to S_H3, S_HCHK,
// S_OUT (four header byte reads through one ring read port); an empty ring or no pending
// data goes from S_H0 or S_RD0 to S_OUT; a plain character has no result and only uses
// S_CHAR; an end mark adds S_CFREE, then S_OUT on a drop or S_COPY, S_CFIN, S_OUT
// throughput: one request at a time, the next is taken once busy falls
// reset: control state and indexes clear at once; memories are not cleared; no stalls
module hex_frame_receiver_with_command_ring_top #(
    parameter int FRAME_BYTES = hfr_pkg::FRAME_BYTES_DEF,
    parameter int RING_BYTES  = hfr_pkg::RING_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  hfr_pkg::hfr_in_t req,
    output logic             busy,
    output logic             strobe,
    output hfr_pkg::hfr_out_t result
);

    localparam int FAW = $clog2(FRAME_BYTES);
    localparam int RAW = $clog2(RING_BYTES);
    localparam int FCW = FAW + 1;
    localparam int RCW = RAW + 1;
    localparam int LW  = FAW;
    localparam logic [FCW-1:0] FRAME_FULL = FCW'(FRAME_BYTES);
    localparam logic [RCW-1:0] RING_SIZE  = RCW'(RING_BYTES);
    localparam logic [15:0]    MAX_LEN    = 16'(FRAME_BYTES - hfr_pkg::HDR_BYTES);
    localparam logic [FCW-1:0] HDR_CNT    = FCW'(hfr_pkg::HDR_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_CHAR, S_CFREE, S_COPY, S_CFIN,
        S_H0, S_H1, S_H2, S_H3, S_HCHK, S_RD0, S_RD1, S_OUT
    } state_t;

    state_t            state_reg;
    hfr_pkg::hfr_in_t  req_reg;
    logic [FCW-1:0]    fcount_reg;
    logic              loading_reg;
    logic              expect_hi_reg;
    logic [3:0]        hi_nib_reg;
    logic [RAW-1:0]    rd_idx_reg;
    logic [RAW-1:0]    wr_idx_reg;
    logic              full_reg;
    logic [RAW-1:0]    cursor_reg;
    logic [LW-1:0]     remain_reg;
    logic [FCW-1:0]    copy_reg;
    logic [RCW-1:0]    free_reg;
    logic              strobe_reg;
    hfr_pkg::hfr_out_t res_reg;
    logic [RAW-1:0]    raddr_reg;

    // frame buffer and ring ports
    logic           f_we;
    logic [FAW-1:0] f_waddr;
    logic [7:0]     f_wdata;
    logic [7:0]     f_rdata;
    logic           r_we;
    logic [RAW-1:0] r_waddr;
    logic [7:0]     r_rdata;
    logic [4:0]     hexv;
    logic           f_we_reg;
    logic [RAW-1:0] wr_pos;

    hfr_byte_ram #(.DEPTH(FRAME_BYTES), .AW(FAW)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(copy_reg[FAW-1:0]), .rdata(f_rdata)
    );

    hfr_byte_ram #(.DEPTH(RING_BYTES), .AW(RAW)) u_ring (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(f_rdata),
        .raddr(raddr_reg), .rdata(r_rdata)
    );

    assign hexv    = hfr_pkg::hex_decode(req_reg.rx_char);
    assign f_we    = f_we_reg;
    assign f_waddr = fcount_reg[FAW-1:0];
    assign f_wdata = {hi_nib_reg, hexv[3:0]};
    // copy write stores the frame byte read in the cycle before, one address behind
    assign wr_pos  = wr_idx_reg + RAW'(copy_reg - FCW'(1));
    assign r_we    = (state_reg == S_COPY) && (copy_reg != '0);
    assign r_waddr = wr_pos;
    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign result  = res_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcount_reg    <= '0;
            loading_reg   <= 1'b0;
            expect_hi_reg <= 1'b1;
            hi_nib_reg    <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            full_reg      <= 1'b0;
            cursor_reg    <= '0;
            remain_reg    <= '0;
            copy_reg      <= '0;
            free_reg      <= '0;
            strobe_reg    <= 1'b0;
            f_we_reg      <= 1'b0;
            res_reg       <= '0;
            raddr_reg     <= '0;
            req_reg       <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            f_we_reg   <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req;
                        res_reg <= '0;
                        case (req.opcode)
                            hfr_pkg::OP_CHAR: state_reg <= S_CHAR;
                            hfr_pkg::OP_DEQ:
                            begin
                                raddr_reg <= rd_idx_reg;
                                state_reg <= S_H0;
                            end
                            hfr_pkg::OP_READ:
                            begin
                                raddr_reg <= cursor_reg;
                                state_reg <= S_RD0;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                // character handling
                S_CHAR:
                begin
                    state_reg <= S_IDLE;
                    if (req_reg.rx_char == hfr_pkg::START_MARK)
                    begin
                        loading_reg   <= 1'b1;
                        expect_hi_reg <= 1'b1;
                        fcount_reg    <= '0;
                    end
                    else if (loading_reg)
                    begin
                        if (req_reg.rx_char == hfr_pkg::END_MARK &&
                            fcount_reg >= HDR_CNT && expect_hi_reg)
                        begin
                            loading_reg <= 1'b0;
                            res_reg.kind <= hfr_pkg::KIND_FRAME;
                            if (rd_idx_reg <= wr_idx_reg)
                                free_reg <= RING_SIZE - RCW'(wr_idx_reg - rd_idx_reg);
                            else
                                free_reg <= RCW'(rd_idx_reg - wr_idx_reg);
                            state_reg <= S_CFREE;
                        end
                        else if (hexv[4] && fcount_reg < FRAME_FULL)
                        begin
                            if (expect_hi_reg)
                                hi_nib_reg <= hexv[3:0];
                            else
                                f_we_reg <= 1'b1;
                            expect_hi_reg <= !expect_hi_reg;
                        end
                        else
                            loading_reg <= 1'b0;
                    end
                end
                S_CFREE:
                begin
                    if (full_reg || RCW'(fcount_reg) > free_reg)
                    begin
                        res_reg.status <= hfr_pkg::ST_NO_ROOM;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        copy_reg  <= '0;
                        state_reg <= S_COPY;
                    end
                end
                // one byte per cycle from frame buffer to ring
                S_COPY:
                begin
                    if (copy_reg == fcount_reg)
                        state_reg <= S_CFIN;
                    else
                        copy_reg <= copy_reg + FCW'(1);
                end
                S_CFIN:
                begin
                    wr_idx_reg <= wr_idx_reg + RAW'(fcount_reg);
                    full_reg   <= (rd_idx_reg == RAW'(wr_idx_reg + RAW'(fcount_reg)));
                    res_reg.status <= hfr_pkg::ST_OK;
                    state_reg  <= S_OUT;
                end
                // header read, one byte per cycle
                S_H0:
                begin
                    remain_reg <= '0;
                    res_reg.kind <= hfr_pkg::KIND_HDR;
                    if (!full_reg && rd_idx_reg == wr_idx_reg)
                    begin
                        res_reg.status <= hfr_pkg::ST_EMPTY;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        raddr_reg <= rd_idx_reg + RAW'(1);
                        state_reg <= S_H1;
                    end
                end
                S_H1:
                begin
                    res_reg.cmd_id[7:0] <= r_rdata;
                    raddr_reg <= rd_idx_reg + RAW'(2);
                    state_reg <= S_H2;
                end
                S_H2:
                begin
                    res_reg.cmd_id[15:8] <= r_rdata;
                    raddr_reg <= rd_idx_reg + RAW'(3);
                    state_reg <= S_H3;
                end
                S_H3:
                begin
                    res_reg.data_len[7:0] <= r_rdata;
                    state_reg <= S_HCHK;
                end
                S_HCHK:
                begin
                    res_reg.data_len[15:8] <= r_rdata;
                    state_reg <= S_OUT;
                    if ({r_rdata, res_reg.data_len[7:0]} > MAX_LEN)
                        res_reg.status <= hfr_pkg::ST_TOO_BIG;
                    else
                    begin
                        res_reg.status <= hfr_pkg::ST_OK;
                        cursor_reg <= rd_idx_reg + RAW'(hfr_pkg::HDR_BYTES);
                        remain_reg <= LW'({r_rdata, res_reg.data_len[7:0]});
                        if ({r_rdata, res_reg.data_len[7:0]} == 16'd0)
                        begin
                            rd_idx_reg <= rd_idx_reg + RAW'(hfr_pkg::HDR_BYTES);
                            full_reg   <= 1'b0;
                        end
                    end
                end
                // data byte read
                S_RD0:
                begin
                    res_reg.kind <= hfr_pkg::KIND_DATA;
                    if (remain_reg == '0)
                    begin
                        res_reg.status <= hfr_pkg::ST_NO_DATA;
                        state_reg      <= S_OUT;
                    end
                    else
                        state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    res_reg.status    <= hfr_pkg::ST_OK;
                    res_reg.data_byte <= r_rdata;
                    cursor_reg <= cursor_reg + RAW'(1);
                    remain_reg <= remain_reg - LW'(1);
                    if (remain_reg == LW'(1))
                    begin
                        res_reg.last <= 1'b1;
                        rd_idx_reg   <= cursor_reg + RAW'(1);
                        full_reg     <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    strobe_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (f_we_reg)
                fcount_reg <= fcount_reg + FCW'(1);
        end
    end

    // no result while a request is still being worked on
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> !busy)
        else $error("strobe while busy");
    // a request always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy &&
        req.opcode != hfr_pkg::OP_UNUSED) |=> busy)
        else $error("request not taken");
    // the pending count never exceeds the largest length
    assert property (@(posedge clk) disable iff (!rst_n)
        16'(remain_reg) <= MAX_LEN)
        else $error("pending count out of range");
    // frame count never passes the buffer size
    assert property (@(posedge clk) disable iff (!rst_n) fcount_reg <= FRAME_FULL)
        else $error("frame count overflow");

endmodule

// File: hdl/hfr_top_dummy_unused.sv
module hfr_byte_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
